// ===== sv/sid_pkg.sv =====
// Shared constants, types and state encoding for the signed integer divider.
package sid_pkg;

	// Operand and quotient width
	localparam int DATA_WIDTH = 32;
	// Iteration counter width, counts DATA_WIDTH-1 down to 0
	localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
	// Output sideband width and bit positions
	localparam int TUSER_W = 2;
	localparam int U_OVERFLOW = 0;
	localparam int U_DIV_ZERO = 1;

	// Saturation and most negative values
	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} sid_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} sid_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last;
		logic out_free;
	} sid_sts_t;

	// Two's complement magnitude of a signed word
	function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		r = v[DATA_WIDTH-1] ? (~v + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : v;
		return r;
	endfunction

endpackage

// ===== sv/sid_ctrl.sv =====
// Controller state machine that sequences load, iteration and result write.
module sid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  sid_pkg::sid_sts_t sts,
	output sid_pkg::sid_cmd_t cmd
);

	sid_pkg::sid_state_t state_q;
	sid_pkg::sid_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sid_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = sid_pkg::ST_RUN;
			end
			sid_pkg::ST_RUN: begin
				if (sts.last) state_d = sid_pkg::ST_FIN;
			end
			sid_pkg::ST_FIN: begin
				if (sts.out_free) state_d = sid_pkg::ST_IDLE;
			end
			default: state_d = sid_pkg::ST_IDLE;
		endcase
	end

	// Outputs: request acceptance and datapath commands
	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			sid_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			sid_pkg::ST_RUN: begin
				cmd.step = 1'b1;
			end
			sid_pkg::ST_FIN: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/sid_dp.sv =====
// Datapath: operand magnitudes, restoring shift-subtract step and result register.
module sid_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [2*sid_pkg::DATA_WIDTH-1:0]    s_tdata,
	output logic [sid_pkg::DATA_WIDTH-1:0]      m_tdata,
	output logic [sid_pkg::TUSER_W-1:0]         m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  sid_pkg::sid_cmd_t                   cmd,
	output sid_pkg::sid_sts_t                   sts
);

	localparam int W = sid_pkg::DATA_WIDTH;

	logic [W-1:0]              rem_q;
	logic [W-1:0]              quo_q;
	logic [W-1:0]              dsr_q;
	logic [sid_pkg::CNT_W-1:0] cnt_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic                      dz_q;
	logic [W-1:0]              out_q;
	logic                      out_ovf_q;
	logic                      out_dz_q;
	logic                      out_valid_q;

	logic [W-1:0] dvd;
	logic [W-1:0] dvs;
	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic         take;
	logic [W-1:0] result;

	assign dvd = s_tdata[W-1:0];
	assign dvs = s_tdata[2*W-1:W];

	// One restoring step: shift in the next dividend bit, try the subtract
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign take    = ~diff[W];

	// Apply special cases and sign
	always_comb begin
		if (dz_q) begin
			result = '0;
		end else if (ovf_q) begin
			result = sid_pkg::MAX_POS;
		end else if (neg_q) begin
			result = ~quo_q + {{(W-1){1'b0}}, 1'b1};
		end else begin
			result = quo_q;
		end
	end

	// Load operands, then iterate one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= sid_pkg::magnitude(dvd);
			dsr_q <= sid_pkg::magnitude(dvs);
			cnt_q <= sid_pkg::CNT_W'(W - 1);
			neg_q <= dvd[W-1] ^ dvs[W-1];
			dz_q  <= (dvs == '0);
			ovf_q <= (dvd == sid_pkg::MIN_NEG) && (dvs == '1);
		end else if (cmd.step) begin
			rem_q <= take ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], take};
			cnt_q <= cnt_q - sid_pkg::CNT_W'(1);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q     <= result;
			out_ovf_q <= ovf_q & ~dz_q;
			out_dz_q  <= dz_q;
		end
	end

	// Result valid: set on write, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.last     = (cnt_q == '0);
	assign sts.out_free = ~out_valid_q | m_tready;

	assign m_tdata                     = out_q;
	assign m_tuser[sid_pkg::U_OVERFLOW] = out_ovf_q;
	assign m_tuser[sid_pkg::U_DIV_ZERO] = out_dz_q;
	assign m_tvalid                    = out_valid_q;

endmodule

// ===== sv/signed_integer_divider.sv =====
// Top level of the signed integer divider: controller plus datapath.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[31:0] dividend, s_tdata[63:32] divisor
//  m_*      out  m_tvalid/m_tready  m_tdata quotient, m_tuser overflow, divide_by_zero
//
// One request at a time: an accepted request is iterated one quotient bit per
// iteration cycle (restoring subtract), then signed and written to the result
// register once the output is free; the next request is taken after that write.
// A result waiting on m_tready does not block a new request; only the write of
// the following result waits for the output register to empty.
// Reset (arst_n low) clears the controller and the output valid.
module signed_integer_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] dividend, [63:32] divisor
	input  logic [2*sid_pkg::DATA_WIDTH-1:0]   s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] quotient
	output logic [sid_pkg::DATA_WIDTH-1:0]     m_tdata,
	// [0] overflow, [1] divide_by_zero
	output logic [sid_pkg::TUSER_W-1:0]        m_tuser
);

	sid_pkg::sid_cmd_t cmd;
	sid_pkg::sid_sts_t sts;

	sid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sid_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

`ifndef SYNTH
	// A new result only appears after a write command
	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.finish))
		else $error("result valid rose without a write");

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	// Only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

	// Overflow and divide by zero are exclusive
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[sid_pkg::U_OVERFLOW] && m_tuser[sid_pkg::U_DIV_ZERO]))
		else $error("both flags set");
`endif

endmodule

// ===== verif/signed_integer_divider_tb.sv =====
// Self-checking stream testbench for the signed integer divider: directed and random requests.
module signed_integer_divider_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = sid_pkg::DATA_WIDTH;
	localparam logic [W-1:0] MINUS_ONE = '1;
	localparam int RANDOM_REQUESTS = 1750;
	localparam int N_PHASES = 4;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 800000;
	localparam int REPORT_LIMIT = 10;
	localparam int N_DIRECTED = 24;

	// Percent of cycles the sender idles and the receiver stalls, per phase
	localparam int PHASE_IDLE[N_PHASES] = '{0, 57, 0, 22};
	localparam int PHASE_STALL[N_PHASES] = '{0, 0, 57, 22};

	typedef struct packed {
		logic [W-1:0] quotient;
		logic         overflow;
		logic         div_zero;
	} quotient_t;

	typedef struct packed {
		logic [W-1:0] dividend;
		logic [W-1:0] divisor;
		logic         typed;
		quotient_t    result;
	} div_row_t;

	// Directed requests; typed rows carry their result, the rest go through the predictor
	localparam div_row_t DIRECTED_ROWS[N_DIRECTED] = '{
		// zero divisor: flag set, quotient zero
		'{32'd0,            32'd0,            1'b1, '{32'd0, 1'b0, 1'b1}},
		'{sid_pkg::MAX_POS, 32'd0,            1'b1, '{32'd0, 1'b0, 1'b1}},
		'{sid_pkg::MIN_NEG, 32'd0,            1'b1, '{32'd0, 1'b0, 1'b1}},
		'{MINUS_ONE,        32'd0,            1'b1, '{32'd0, 1'b0, 1'b1}},
		// most negative over minus one saturates
		'{sid_pkg::MIN_NEG, MINUS_ONE,        1'b1, '{sid_pkg::MAX_POS, 1'b1, 1'b0}},
		// extremes
		'{sid_pkg::MAX_POS, 32'd1,            1'b1, '{sid_pkg::MAX_POS, 1'b0, 1'b0}},
		'{sid_pkg::MIN_NEG, 32'd1,            1'b1, '{sid_pkg::MIN_NEG, 1'b0, 1'b0}},
		'{sid_pkg::MAX_POS, MINUS_ONE,        1'b1, '{32'h8000_0001, 1'b0, 1'b0}},
		'{sid_pkg::MIN_NEG, sid_pkg::MIN_NEG, 1'b1, '{32'd1, 1'b0, 1'b0}},
		'{sid_pkg::MAX_POS, sid_pkg::MAX_POS, 1'b1, '{32'd1, 1'b0, 1'b0}},
		'{32'd0,            sid_pkg::MIN_NEG, 1'b1, '{32'd0, 1'b0, 1'b0}},
		'{MINUS_ONE,        MINUS_ONE,        1'b1, '{32'd1, 1'b0, 1'b0}},
		'{32'd0,            MINUS_ONE,        1'b1, '{32'd0, 1'b0, 1'b0}},
		// sign combinations and truncation toward zero
		'{32'd7,            32'd2,            1'b0, '0},
		'{-32'sd7,          32'd2,            1'b0, '0},
		'{32'd7,            -32'sd2,          1'b0, '0},
		'{-32'sd7,          -32'sd2,          1'b0, '0},
		'{sid_pkg::MIN_NEG, 32'd2,            1'b0, '0},
		'{sid_pkg::MIN_NEG, sid_pkg::MAX_POS, 1'b0, '0},
		'{sid_pkg::MAX_POS, sid_pkg::MIN_NEG, 1'b0, '0},
		'{32'd1,            sid_pkg::MAX_POS, 1'b0, '0},
		'{32'd100,          32'd7,            1'b0, '0},
		'{32'hDEAD_BEEF,    32'h0000_1234,    1'b0, '0},
		'{32'h1234_5678,    32'hFFFF_FF00,    1'b0, '0}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// [31:0] dividend, [63:32] divisor
	logic [2*W-1:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [31:0] quotient
	logic [W-1:0] m_tdata;
	// [0] overflow, [1] divide_by_zero
	logic [sid_pkg::TUSER_W-1:0] m_tuser;

	quotient_t pending_quotients[$];
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int zero_divisors_seen = 0;
	int saturations_seen = 0;
	int error_count = 0;
	int cycle_count = 0;

	signed_integer_divider dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Quotient truncated toward zero by restoring division on magnitudes
	function automatic quotient_t predict_quotient(input logic [W-1:0] num,
			input logic [W-1:0] den);
		quotient_t r;
		logic [W-1:0] abs_num;
		logic [W-1:0] abs_den;
		logic [W-1:0] q;
		logic [W:0] partial;
		r = '0;
		if (den == '0) begin
			r.div_zero = 1'b1;
		end else if (num == sid_pkg::MIN_NEG && den == MINUS_ONE) begin
			r.quotient = sid_pkg::MAX_POS;
			r.overflow = 1'b1;
		end else begin
			abs_num = num[W-1] ? -num : num;
			abs_den = den[W-1] ? -den : den;
			partial = '0;
			q = '0;
			for (int i = W - 1; i >= 0; i--) begin
				partial = {partial[W-1:0], abs_num[i]};
				if (partial >= {1'b0, abs_den}) begin
					partial = partial - {1'b0, abs_den};
					q[i] = 1'b1;
				end
			end
			r.quotient = (num[W-1] ^ den[W-1]) ? -q : q;
		end
		return r;
	endfunction

	// Operand mix: full-range words, small values, extremes, powers of two, short words
	function automatic logic [W-1:0] random_operand();
		logic [W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4: v = $urandom_range(32) - 16;
			5: begin
				case ($urandom_range(5))
					0: v = sid_pkg::MIN_NEG;
					1: v = sid_pkg::MAX_POS;
					2: v = MINUS_ONE;
					3: v = '0;
					4: v = 32'd1;
					default: v = sid_pkg::MIN_NEG + 32'd1;
				endcase
			end
			6: begin
				v = 32'd1 << $urandom_range(W - 1);
				if ($urandom_range(1) == 1) v = -v;
			end
			default: begin
				v = $urandom >> $urandom_range(W - 1);
				if ($urandom_range(1) == 1) v = -v;
			end
		endcase
		return v;
	endfunction

	// Offer one request after a random idle gap; hold valid high until it is taken
	task automatic send_request(input logic [W-1:0] dividend, input logic [W-1:0] divisor,
			input quotient_t expected);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {divisor, dividend};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_quotients.push_back(expected);
		requests_sent++;
	endtask

	task automatic report_mismatch(input string what, input quotient_t want,
			input quotient_t got);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("MISMATCH %s at result %0d: expected q=%0d ovf=%b dz=%b, %s",
				what, results_seen, $signed(want.quotient), want.overflow, want.div_zero,
				$sformatf("got q=%0d ovf=%b dz=%b",
					$signed(got.quotient), got.overflow, got.div_zero));
		end
	endtask

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Compare each delivered quotient with the oldest expectation
	always @(posedge clk) begin
		quotient_t got;
		quotient_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata, m_tuser[sid_pkg::U_OVERFLOW], m_tuser[sid_pkg::U_DIV_ZERO]};
			results_seen++;
			if (got.div_zero) zero_divisors_seen++;
			if (got.overflow) saturations_seen++;
			if (pending_quotients.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_quotients.pop_front();
				if (got.quotient !== want.quotient || got.overflow !== want.overflow
						|| got.div_zero !== want.div_zero) begin
					report_mismatch("wrong result", want, got);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_quotients.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [W-1:0] num;
		logic [W-1:0] den;
		int pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with no idling
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(DIRECTED_ROWS[i].dividend, DIRECTED_ROWS[i].divisor,
				DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].result
					: predict_quotient(DIRECTED_ROWS[i].dividend, DIRECTED_ROWS[i].divisor));
		end

		// Random requests, one idle/stall mix per phase
		for (int phase = 0; phase < N_PHASES; phase++) begin
			sender_idle_pct = PHASE_IDLE[phase];
			receiver_stall_pct = PHASE_STALL[phase];
			for (int k = 0; k < RANDOM_REQUESTS / N_PHASES; k++) begin
				pick = $urandom_range(49);
				num = random_operand();
				if (pick == 0) begin
					num = sid_pkg::MIN_NEG;
					den = MINUS_ONE;
				end else if (pick == 1) begin
					den = '0;
				end else begin
					den = random_operand();
				end
				send_request(num, den, predict_quotient(num, den));
			end
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (pending_quotients.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d from the table) through four idle/stall mixes, %0d results.",
			requests_sent, N_DIRECTED, results_seen);
		$display("Saw %0d zero divisors and %0d saturations; %0d mismatches.",
			zero_divisors_seen, saturations_seen, error_count);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
